// ----- hw/rtl/pcgd_pkg.sv -----
// Package for the pixel colour gain distortion core.
// Holds the register index codes, per-lane gain struct and the quarter sine table.
// No dependencies.
`default_nettype none

package pcgd_pkg;

  localparam int Channels = 3;
  localparam int GainW    = 16;
  localparam int SizeW    = 13;
  localparam int CfgW     = 48;
  localparam int CfgIdxW  = 3;
  localparam int FracBits = 27;
  localparam int QsW      = 15;
  localparam int QsEntries = 65;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOffsetGains = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSineGains   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgColumnGains = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRowGains    = 3'd5;

  localparam logic [SizeW-1:0] SizeReset = 13'd512;

  localparam longint unsigned PiQ30 = 64'd3373259426;

  // exact floor division of a Taylor term by (2n)(2n+1), entry 0 for n = 1
  localparam int RecipShift = 44;
  localparam logic [9:0][63:0] TaylorRecip = {
    ((64'd1 << RecipShift) + 64'd419) / 64'd420,
    ((64'd1 << RecipShift) + 64'd341) / 64'd342,
    ((64'd1 << RecipShift) + 64'd271) / 64'd272,
    ((64'd1 << RecipShift) + 64'd209) / 64'd210,
    ((64'd1 << RecipShift) + 64'd155) / 64'd156,
    ((64'd1 << RecipShift) + 64'd109) / 64'd110,
    ((64'd1 << RecipShift) + 64'd71) / 64'd72,
    ((64'd1 << RecipShift) + 64'd41) / 64'd42,
    ((64'd1 << RecipShift) + 64'd19) / 64'd20,
    ((64'd1 << RecipShift) + 64'd5) / 64'd6
  };

  typedef struct packed {
    logic signed [GainW-1:0] offset_gain;
    logic signed [GainW-1:0] sine_gain;
    logic signed [GainW-1:0] column_gain;
    logic signed [GainW-1:0] row_gain;
  } lane_cfg_t;

  // Q14 quarter wave, Taylor series in Q30 rounded to Q14
  function automatic logic [QsEntries*QsW-1:0] build_quarter_sine();
    logic [QsEntries*QsW-1:0] tbl;
    longint unsigned x;
    longint unsigned term;
    longint signed sum;
    logic [127:0] wide;
    tbl = '0;
    for (int k = 0; k < QsEntries; k++) begin
      x = (PiQ30 * longint'(k)) >> 7;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        wide = 128'(term) * 128'(TaylorRecip[n-1]);
        term = 64'(wide >> RecipShift);
        if ((n & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tbl[k*QsW +: QsW] = QsW'((longint'(sum) + 32768) >>> 16);
    end
    return tbl;
  endfunction

  localparam logic [QsEntries*QsW-1:0] QuarterSine = build_quarter_sine();

  function automatic logic signed [15:0] sine_q14(logic signed [7:0] c);
    logic [7:0] mag;
    logic [6:0] k;
    logic [QsW-1:0] v;
    mag = c[7] ? 8'(-c) : 8'(c);
    k = (mag <= 8'd64) ? mag[6:0] : 7'(8'd128 - mag);
    v = QuarterSine[int'(k)*QsW +: QsW];
    return c[7] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pcgd_coord.sv -----
// Column and row position tracking for the distortion core.
// Produces the doubled centre offsets 2x-W and 2y-H; uses pcgd_pkg.
`default_nettype none

module pcgd_coord #(
  parameter int COORD_BITS = 12,
  parameter int DX_W       = 14
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          accept_i,
  input  wire logic                          frame_start_i,
  input  wire logic [pcgd_pkg::SizeW-1:0]    width_i,
  input  wire logic [pcgd_pkg::SizeW-1:0]    height_i,
  output logic signed [DX_W-1:0]             dx_o,
  output logic signed [DX_W-1:0]             dy_o
);

  localparam int CmpW = (COORD_BITS + 1 > pcgd_pkg::SizeW) ? COORD_BITS + 1 : pcgd_pkg::SizeW;

  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [COORD_BITS-1:0] col_eff, row_eff;
  logic [COORD_BITS:0]   col_next, row_next;
  logic                  col_wrap, row_wrap;
  logic signed [DX_W-1:0] dx_q, dx_d, dy_q, dy_d;

  assign col_eff = frame_start_i ? '0 : col_q;
  assign row_eff = frame_start_i ? '0 : row_q;

  assign col_next = {1'b0, col_eff} + (COORD_BITS+1)'(1);
  assign row_next = {1'b0, row_eff} + (COORD_BITS+1)'(1);
  assign col_wrap = col_next[COORD_BITS] || (CmpW'(col_next) >= CmpW'(width_i));
  assign row_wrap = row_next[COORD_BITS] || (CmpW'(row_next) >= CmpW'(height_i));

  always_comb begin
    col_d = col_wrap ? '0 : col_next[COORD_BITS-1:0];
    row_d = row_eff;
    if (col_wrap) begin
      row_d = row_wrap ? '0 : row_next[COORD_BITS-1:0];
    end
  end

  assign dx_d = $signed(DX_W'({col_eff, 1'b0})) - $signed(DX_W'(width_i));
  assign dy_d = $signed(DX_W'({row_eff, 1'b0})) - $signed(DX_W'(height_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign dx_o = dx_q;
  assign dy_o = dy_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pcgd_lane.sv -----
// One channel lane: sine lookup, gain factor, product, truncation and clamp.
// Four register stages under a common advance; uses pcgd_pkg.
`default_nettype none

module pcgd_lane #(
  parameter int DX_W = 14
) (
  input  wire logic                     clk_i,
  input  wire logic                     adv_i,
  input  wire logic [7:0]               chan_i,
  input  wire pcgd_pkg::lane_cfg_t      cfg_i,
  input  wire logic signed [DX_W-1:0]   dx_i,
  input  wire logic signed [DX_W-1:0]   dy_i,
  output logic [7:0]                    chan_o
);

  localparam int PSineW = 2 * pcgd_pkg::GainW;
  localparam int PPosW  = pcgd_pkg::GainW + DX_W;
  localparam int FW     = ((PPosW + 6 > PSineW) ? PPosW + 6 : PSineW) + 3;
  localparam int PW     = FW + 8;
  localparam int QW     = PW - pcgd_pkg::FracBits;

  logic signed [7:0]        c1_q, c2_q, c3_q;
  logic signed [15:0]       s1_q;
  logic signed [PSineW-1:0] p_sine_q;
  logic signed [PPosW-1:0]  p_col_q, p_row_q;
  logic signed [FW-1:0]     f3_q, f3_d;
  logic signed [PW-1:0]     prod_q;
  logic signed [QW-1:0]     q_floor, q_trunc;
  logic [7:0]               byte_sat;

  always_comb begin
    f3_d = (FW'(1) <<< pcgd_pkg::FracBits)
         + (FW'(cfg_i.offset_gain) <<< 14)
         + FW'(p_sine_q)
         + (FW'(p_col_q) <<< 6)
         + (FW'(p_row_q) <<< 6);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c1_q     <= $signed(chan_i ^ 8'h80);
      s1_q     <= pcgd_pkg::sine_q14($signed(chan_i ^ 8'h80));
      c2_q     <= c1_q;
      p_sine_q <= PSineW'(cfg_i.sine_gain) * PSineW'(s1_q);
      p_col_q  <= PPosW'(cfg_i.column_gain) * PPosW'(dx_i);
      p_row_q  <= PPosW'(cfg_i.row_gain) * PPosW'(dy_i);
      c3_q     <= c2_q;
      f3_q     <= f3_d;
      prod_q   <= PW'(c3_q) * PW'(f3_q);
    end
  end

  // truncate toward zero, then saturate
  always_comb begin
    q_floor = prod_q[PW-1:pcgd_pkg::FracBits];
    q_trunc = q_floor;
    if (prod_q[PW-1] && (|prod_q[pcgd_pkg::FracBits-1:0])) begin
      q_trunc = q_floor + QW'(1);
    end
    if (q_trunc > $signed(QW'(127))) begin
      byte_sat = 8'd127;
    end else if (q_trunc < $signed(-QW'(128))) begin
      byte_sat = 8'h80;
    end else begin
      byte_sat = q_trunc[7:0];
    end
  end

  assign chan_o = byte_sat ^ 8'h80;

endmodule

`default_nettype wire

// ----- hw/rtl/pixel_color_gain_distort_core.sv -----
// An input transfer passes through the lane stages and the output register to its output transfer.
// Throughput: one pixel per cycle while the output is not stalled.
// A stalled output freezes all stages; input ready follows the output stage.
// Reset clears position counters and valid flags and sets the config registers (W = H = 512, gains 0);
// data registers are not reset. Uses pcgd_pkg, pcgd_coord and pcgd_lane.
`default_nettype none

module pixel_color_gain_distort_core #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pcgd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [pcgd_pkg::CfgW-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      in_chan0_i,
  input  wire logic [7:0]                      in_chan1_i,
  input  wire logic [7:0]                      in_chan2_i,
  input  wire logic                            frame_start_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [7:0]                           out_chan0_o,
  output logic [7:0]                           out_chan1_o,
  output logic [7:0]                           out_chan2_o
);

  localparam int DxW = ((COORD_BITS + 1 > pcgd_pkg::SizeW) ? COORD_BITS + 1
                                                           : pcgd_pkg::SizeW) + 1;
  localparam int Stages = 4;

  logic [pcgd_pkg::SizeW-1:0] width_q, height_q;
  logic [pcgd_pkg::CfgW-1:0]  offset_gains_q, sine_gains_q, column_gains_q, row_gains_q;

  logic                  adv, accept;
  logic [Stages-1:0]     v_q;
  logic                  out_valid_q;
  logic signed [DxW-1:0] dx, dy;

  logic [7:0]            chan_in  [pcgd_pkg::Channels];
  logic [7:0]            chan_res [pcgd_pkg::Channels];
  logic [7:0]            out_chan_q [pcgd_pkg::Channels];
  pcgd_pkg::lane_cfg_t   lane_cfg [pcgd_pkg::Channels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q        <= pcgd_pkg::SizeReset;
      height_q       <= pcgd_pkg::SizeReset;
      offset_gains_q <= '0;
      sine_gains_q   <= '0;
      column_gains_q <= '0;
      row_gains_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcgd_pkg::CfgFrameWidth:  width_q        <= cfg_wdata_i[pcgd_pkg::SizeW-1:0];
        pcgd_pkg::CfgFrameHeight: height_q       <= cfg_wdata_i[pcgd_pkg::SizeW-1:0];
        pcgd_pkg::CfgOffsetGains: offset_gains_q <= cfg_wdata_i;
        pcgd_pkg::CfgSineGains:   sine_gains_q   <= cfg_wdata_i;
        pcgd_pkg::CfgColumnGains: column_gains_q <= cfg_wdata_i;
        pcgd_pkg::CfgRowGains:    row_gains_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && adv;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[Stages-2:0], in_valid_i};
      out_valid_q <= v_q[Stages-1];
    end
  end

  pcgd_coord #(
    .COORD_BITS (COORD_BITS),
    .DX_W       (DxW)
  ) u_coord (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .accept_i      (accept),
    .frame_start_i (frame_start_i),
    .width_i       (width_q),
    .height_i      (height_q),
    .dx_o          (dx),
    .dy_o          (dy)
  );

  assign chan_in[0] = in_chan0_i;
  assign chan_in[1] = in_chan1_i;
  assign chan_in[2] = in_chan2_i;

  for (genvar ch = 0; ch < pcgd_pkg::Channels; ch++) begin : g_lane
    assign lane_cfg[ch].offset_gain = offset_gains_q[pcgd_pkg::GainW*ch +: pcgd_pkg::GainW];
    assign lane_cfg[ch].sine_gain   = sine_gains_q[pcgd_pkg::GainW*ch +: pcgd_pkg::GainW];
    assign lane_cfg[ch].column_gain = column_gains_q[pcgd_pkg::GainW*ch +: pcgd_pkg::GainW];
    assign lane_cfg[ch].row_gain    = row_gains_q[pcgd_pkg::GainW*ch +: pcgd_pkg::GainW];

    pcgd_lane #(
      .DX_W (DxW)
    ) u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .chan_i (chan_in[ch]),
      .cfg_i  (lane_cfg[ch]),
      .dx_i   (dx),
      .dy_i   (dy),
      .chan_o (chan_res[ch])
    );

    always_ff @(posedge clk_i) begin
      if (adv) begin
        out_chan_q[ch] <= chan_res[ch];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_chan0_o = out_chan_q[0];
  assign out_chan1_o = out_chan_q[1];
  assign out_chan2_o = out_chan_q[2];

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v_q[0])
    else $error("accepted pixel did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q) && out_valid_q)
    else $error("pipeline moved while the output was stalled");

  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v_q[Stages-1]))
    else $error("output valid without a pixel in the last stage");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_pixel_color_gain_distort_core.sv -----
// Self-checking testbench for pixel_color_gain_distort_core: directed and random pixel
// streams over valid/ready, each transfer checked against an in-bench gain model or,
// for the identity rows, a fixed expected pixel. Depends on pcgd_pkg and the core RTL.
module tb_pixel_color_gain_distort_core;

  localparam int Chans         = pcgd_pkg::Channels;
  localparam int CoordMax      = 4095;
  localparam longint OneQ27    = 64'sd134217728;
  localparam longint unsigned HalfTurnQ30 = 64'd3373259426;
  localparam int MaxGap        = 17;
  localparam int HoldOffCycles = 240;
  localparam int RandomPhases  = 10;
  localparam int PhaseItems    = 100;
  localparam int PressurePhase = 3;
  localparam int WideRowItems  = 230;
  localparam int SettleCycles  = 12;
  localparam int MaxReports    = 40;
  localparam int DirCount      = 20;

  localparam logic [pcgd_pkg::CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [pcgd_pkg::CfgIdxW-1:0] CfgSpareHi = 3'd7;

  typedef logic [Chans-1:0][7:0] pixel_t;

  typedef struct packed {
    logic [pcgd_pkg::SizeW-1:0] width;
    logic [pcgd_pkg::SizeW-1:0] height;
    logic [pcgd_pkg::CfgW-1:0]  offset_g;
    logic [pcgd_pkg::CfgW-1:0]  sine_g;
    logic [pcgd_pkg::CfgW-1:0]  column_g;
    logic [pcgd_pkg::CfgW-1:0]  row_g;
  } frame_cfg_t;

  typedef struct packed {
    int     preset;
    pixel_t chan;
    logic   frame_start;
    logic   typed;
    pixel_t want;
  } stim_row_t;

  localparam frame_cfg_t DirCfg [3] = '{
    '{13'd3, 13'd2, 48'h0000_8000_7FFF, 48'h8000_7FFF_0000,
      48'h7FFF_0000_8000, 48'h0400_8000_7FFF},
    '{13'd0, 13'd0, 48'hFF00_0100_0000, 48'h2000_E000_0800,
      48'h7FFF_8000_1234, 48'h8000_7FFF_EDCB},
    '{13'd1, 13'd1, 48'h7FFF_7FFF_8000, 48'h0000_8000_7FFF,
      48'h8000_7FFF_0000, 48'h7FFF_8000_8000}
  };

  localparam frame_cfg_t WideCfg = '{13'h1FFF, 13'd3, 48'h0000_0000_0000,
    48'h0100_0000_FF00, 48'h0020_FFE0_0040, 48'h1000_F000_0000};

  // identity rows run under reset settings, where every gain is zero
  localparam stim_row_t DirRows [DirCount] = '{
    '{-1, 24'h000000, 1'b1, 1'b1, 24'h000000},
    '{-1, 24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF},
    '{-1, 24'h808080, 1'b0, 1'b1, 24'h808080},
    '{-1, 24'h01817F, 1'b0, 1'b1, 24'h01817F},
    '{-1, 24'h0FAA55, 1'b1, 1'b1, 24'h0FAA55},
    '{-1, 24'hC0FE01, 1'b0, 1'b1, 24'hC0FE01},
    '{ 0, 24'h000000, 1'b1, 1'b0, 24'h000000},
    '{-1, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
    '{-1, 24'h408040, 1'b0, 1'b0, 24'h000000},
    '{-1, 24'hC0C0C0, 1'b0, 1'b0, 24'h000000},
    '{-1, 24'h7F817F, 1'b0, 1'b0, 24'h000000},
    '{-1, 24'h01FF80, 1'b0, 1'b0, 24'h000000},
    '{-1, 24'h40C000, 1'b0, 1'b0, 24'h000000},
    '{-1, 24'hFF0001, 1'b0, 1'b0, 24'h000000},
    '{ 1, 24'h123456, 1'b0, 1'b0, 24'h000000},
    '{-1, 24'h89ABCD, 1'b0, 1'b0, 24'h000000},
    '{-1, 24'hFEDCBA, 1'b0, 1'b0, 24'h000000},
    '{ 2, 24'h80FF00, 1'b0, 1'b0, 24'h000000},
    '{-1, 24'h3377BB, 1'b1, 1'b0, 24'h000000},
    '{-1, 24'hE0A060, 1'b0, 1'b0, 24'h000000}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [pcgd_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [pcgd_pkg::CfgW-1:0]    cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [7:0]                  in_chan0_i;
  logic [7:0]                  in_chan1_i;
  logic [7:0]                  in_chan2_i;
  logic                        frame_start_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [7:0]                  out_chan0_o;
  logic [7:0]                  out_chan1_o;
  logic [7:0]                  out_chan2_o;

  int         sine_lut [0:64];
  frame_cfg_t active_cfg;
  int         col_pos;
  int         row_pos;
  pixel_t     expected_pixels [$];
  int         mismatch_count = 0;
  bit         tx_steady;
  bit         rx_steady;
  bit         hold_off_req;

  pixel_color_gain_distort_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_chan0_i    (in_chan0_i),
    .in_chan1_i    (in_chan1_i),
    .in_chan2_i    (in_chan2_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_chan0_o   (out_chan0_o),
    .out_chan1_o   (out_chan1_o),
    .out_chan2_o   (out_chan2_o)
  );

  function automatic void build_sine_lut();
    longint unsigned ang;
    longint unsigned term;
    longint sum;
    for (int k = 0; k <= 64; k++) begin
      ang = (HalfTurnQ30 * 64'(k)) / 128;
      term = ang;
      sum = longint'(ang);
      for (int n = 1; n <= 10; n++) begin
        term = (term * ang) >> 30;
        term = (term * ang) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        sum = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) begin
        sum = 0;
      end
      sine_lut[k] = int'((sum + 32768) >>> 16);
    end
  endfunction

  function automatic longint sine_term(int c);
    int mag;
    int k;
    mag = (c < 0) ? -c : c;
    k = (mag <= 64) ? mag : 128 - mag;
    return (c < 0) ? -longint'(sine_lut[k]) : longint'(sine_lut[k]);
  endfunction

  function automatic longint lane_gain(logic [pcgd_pkg::CfgW-1:0] bundle, int ch);
    logic signed [15:0] g;
    g = bundle[16*ch +: 16];
    return longint'(g);
  endfunction

  function automatic int next_coord(int pos, int limit, output bit wrapped);
    int nxt;
    nxt = pos + 1;
    wrapped = (nxt >= limit) || (nxt > CoordMax);
    return wrapped ? 0 : nxt;
  endfunction

  function automatic pixel_t distort_pixel(pixel_t px, logic frame_start);
    pixel_t res;
    longint dx;
    longint dy;
    longint f;
    longint v;
    int c;
    bit wrapped;
    if (frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    dx = 2 * longint'(col_pos) - longint'(active_cfg.width);
    dy = 2 * longint'(row_pos) - longint'(active_cfg.height);
    for (int ch = 0; ch < Chans; ch++) begin
      c = int'(px[ch]) - 128;
      f = OneQ27
        + lane_gain(active_cfg.offset_g, ch) * 16384
        + lane_gain(active_cfg.sine_g, ch) * sine_term(c)
        + lane_gain(active_cfg.column_g, ch) * dx * 64
        + lane_gain(active_cfg.row_g, ch) * dy * 64;
      v = (longint'(c) * f) / OneQ27;
      if (v > 127) begin
        v = 127;
      end
      if (v < -128) begin
        v = -128;
      end
      res[ch] = 8'(v + 128);
    end
    col_pos = next_coord(col_pos, int'(active_cfg.width), wrapped);
    if (wrapped) begin
      row_pos = next_coord(row_pos, int'(active_cfg.height), wrapped);
    end
    return res;
  endfunction

  function automatic logic [15:0] draw_gain();
    int m;
    m = $urandom_range(0, 3000);
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'h0000;
      default: return 16'(m - 1500);
    endcase
  endfunction

  function automatic logic [pcgd_pkg::SizeW-1:0] draw_size(int cap);
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'h1FFF;
      2: return 13'd4096;
      3: return 13'($urandom);
      default: return 13'($urandom_range(1, cap));
    endcase
  endfunction

  function automatic frame_cfg_t draw_settings();
    frame_cfg_t s;
    s.width  = draw_size(24);
    s.height = draw_size(10);
    s.offset_g = '0;
    s.sine_g   = '0;
    s.column_g = '0;
    s.row_g    = '0;
    for (int ch = 0; ch < Chans; ch++) begin
      s.offset_g[16*ch +: 16] = draw_gain();
      s.sine_g[16*ch +: 16]   = draw_gain();
      s.column_g[16*ch +: 16] = draw_gain();
      s.row_g[16*ch +: 16]    = draw_gain();
    end
    return s;
  endfunction

  task automatic write_reg(logic [pcgd_pkg::CfgIdxW-1:0] idx,
                           logic [pcgd_pkg::CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_settings(frame_cfg_t s);
    write_reg(pcgd_pkg::CfgFrameWidth, 48'(s.width));
    write_reg(pcgd_pkg::CfgFrameHeight, 48'(s.height));
    write_reg(pcgd_pkg::CfgOffsetGains, s.offset_g);
    write_reg(pcgd_pkg::CfgSineGains, s.sine_g);
    write_reg(pcgd_pkg::CfgColumnGains, s.column_g);
    write_reg(pcgd_pkg::CfgRowGains, s.row_g);
    // unmapped index: must leave every register untouched
    write_reg(($urandom_range(0, 1) == 0) ? CfgSpareLo : CfgSpareHi,
              48'({$urandom(), $urandom()}));
    active_cfg = s;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_pixel(pixel_t px, logic fs, logic typed, pixel_t want);
    int gap;
    pixel_t pred;
    gap = tx_steady ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_chan0_i    <= px[0];
    in_chan1_i    <= px[1];
    in_chan2_i    <= px[2];
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    pred = distort_pixel(px, fs);
    expected_pixels = {expected_pixels, (typed ? want : pred)};
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20 * 1000000);
    $display("pixel_color_gain_distort_core: mismatch");
    $finish;
  end

  initial begin
    int gap;
    pixel_t got;
    pixel_t want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, MaxGap);
      if (hold_off_req) begin
        gap = HoldOffCycles;
        hold_off_req = 1'b0;
      end
      @(negedge clk_i);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = {out_chan2_o, out_chan1_o, out_chan0_o};
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("%0t: expected no transfer, got %h", $time, got);
        end
      end else begin
        want = expected_pixels.pop_front();
        for (int ch = 0; ch < Chans; ch++) begin
          if (got[ch] !== want[ch]) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports) begin
              $display("%0t: channel %0d expected %h, got %h", $time, ch, want[ch], got[ch]);
            end
          end
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_chan0_i    = '0;
    in_chan1_i    = '0;
    in_chan2_i    = '0;
    frame_start_i = 1'b0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    hold_off_req  = 1'b0;
    build_sine_lut();
    active_cfg = '{pcgd_pkg::SizeReset, pcgd_pkg::SizeReset, '0, '0, '0, '0};
    col_pos = 0;
    row_pos = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DirCount; r++) begin
      if (DirRows[r].preset >= 0) begin
        drain();
        load_settings(DirCfg[DirRows[r].preset]);
      end
      send_pixel(DirRows[r].chan, DirRows[r].frame_start, DirRows[r].typed, DirRows[r].want);
    end

    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      load_settings(draw_settings());
      tx_steady = ($urandom_range(0, 3) == 0) || (p == PressurePhase);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == PressurePhase && i == 10) begin
          hold_off_req = 1'b1;
        end
        send_pixel(pixel_t'($urandom), (i == 0) || ($urandom_range(0, 49) == 0),
                   1'b0, '0);
      end
    end

    // rows wider than the counter range: large negative column offsets
    drain();
    load_settings(WideCfg);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int i = 0; i < WideRowItems; i++) begin
      send_pixel(pixel_t'($urandom), (i == 0), 1'b0, '0);
    end
    drain();

    if (mismatch_count == 0) begin
      $display("pixel_color_gain_distort_core: match");
    end else begin
      $display("pixel_color_gain_distort_core: mismatch");
    end
    $finish;
  end

endmodule
